FILE: rtl/rprop_pkg.sv
// Package for the RPROP step-size updater: widths, register indexes, reset values,
// and the sign code and store entry types shared by the store, calc and top modules.
// No dependencies.
`default_nettype none

package rprop_pkg;

    localparam int MAX_WEIGHTS = 1024;
    localparam int IDX_W       = $clog2(MAX_WEIGHTS);
    localparam int LEN_W       = 11;
    localparam int GRAD_W      = 32;
    localparam int STEP_W      = 40;
    localparam int UPD_W       = STEP_W + 1;
    localparam int ETA_W       = 18;
    localparam int ETA_FRAC    = 16;
    localparam int PROD_W      = STEP_W + ETA_W;
    localparam int SCALED_W    = PROD_W - ETA_FRAC;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = STEP_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_GROW_RATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHRINK_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_STEP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 3'd5;

    localparam logic [ETA_W-1:0]  RST_GROW_RATE   = 18'd72090;
    localparam logic [ETA_W-1:0]  RST_SHRINK_RATE = 18'd58982;
    localparam logic [STEP_W-1:0] RST_MIN_STEP    = 40'd43;
    localparam logic [STEP_W-1:0] RST_MAX_STEP    = 40'd429496729600;
    localparam logic [STEP_W-1:0] RST_INIT_STEP   = 40'd429496730;
    localparam logic [IDX_W-1:0]  RST_LAST_POS    = IDX_W'(MAX_WEIGHTS - 1);

    // Rounding constant for the Q2.16 scaling: one half of the dropped bits.
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ETA_FRAC - 1);

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } t_sgn;

    // A stored previous update, kept as sign and magnitude.
    typedef struct packed {
        t_sgn              sgn;
        logic [STEP_W-1:0] mag;
    } t_entry;

    typedef struct packed {
        logic [ETA_W-1:0]  grow_rate;
        logic [ETA_W-1:0]  shrink_rate;
        logic [STEP_W-1:0] min_step;
        logic [STEP_W-1:0] max_step;
        logic [STEP_W-1:0] init_step;
        logic [IDX_W-1:0]  last_pos;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/rprop_cfg.sv
// Configuration registers of the RPROP updater and the refill strobe raised
// by a vector length write. Depends on rprop_pkg.
`default_nettype none

module rprop_cfg
    import rprop_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg,
    output logic                       o_refill
);

    t_cfg             r_cfg;
    logic [LEN_W-1:0] vlen;
    logic [IDX_W-1:0] n_last_pos;

    assign vlen = i_cfg_data[LEN_W-1:0];

    // A length of zero acts as one, and a length past the store acts as its depth.
    always_comb begin
        if (vlen == '0) begin
            n_last_pos = '0;
        end else if (vlen > LEN_W'(MAX_WEIGHTS)) begin
            n_last_pos = IDX_W'(MAX_WEIGHTS - 1);
        end else begin
            n_last_pos = IDX_W'(vlen - LEN_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grow_rate   <= RST_GROW_RATE;
            r_cfg.shrink_rate <= RST_SHRINK_RATE;
            r_cfg.min_step    <= RST_MIN_STEP;
            r_cfg.max_step    <= RST_MAX_STEP;
            r_cfg.init_step   <= RST_INIT_STEP;
            r_cfg.last_pos    <= RST_LAST_POS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GROW_RATE:     r_cfg.grow_rate   <= i_cfg_data[ETA_W-1:0];
                REG_SHRINK_RATE:   r_cfg.shrink_rate <= i_cfg_data[ETA_W-1:0];
                REG_MIN_STEP:      r_cfg.min_step    <= i_cfg_data[STEP_W-1:0];
                REG_MAX_STEP:      r_cfg.max_step    <= i_cfg_data[STEP_W-1:0];
                REG_INIT_STEP:     r_cfg.init_step   <= i_cfg_data[STEP_W-1:0];
                REG_VECTOR_LENGTH: r_cfg.last_pos    <= n_last_pos;
                default: ;
            endcase
        end
    end

    assign o_cfg    = r_cfg;
    assign o_refill = i_cfg_we && (i_cfg_idx == REG_VECTOR_LENGTH);

endmodule

`default_nettype wire

FILE: rtl/rprop_store.sv
// Previous-update store: a 1024-entry synchronous memory with a registered read,
// a first-pass fill flag in place of a clearing sweep, and a bypass of the last write.
// Depends on rprop_pkg.
`default_nettype none

module rprop_store
    import rprop_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_refill,
    input  wire logic [STEP_W-1:0] i_init_step,
    input  wire logic              i_rd_en,
    input  wire logic [IDX_W-1:0]  i_rd_idx,
    input  wire logic              i_rd_last,
    input  wire logic              i_wr_en,
    input  wire t_entry            i_wr_data,
    output t_entry                 o_rd_data,
    output logic [IDX_W-1:0]       o_rd_idx
);

    t_entry           mem [MAX_WEIGHTS];
    t_entry           r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_fresh;
    logic             r_first_pass;
    t_entry           r_fill;
    logic             r_byp_valid;
    logic [IDX_W-1:0] r_byp_idx;
    t_entry           r_byp_data;
    logic             byp_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_rd_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
        if (i_wr_en) begin
            r_byp_idx  <= r_rd_idx;
            r_byp_data <= i_wr_data;
        end
    end

    // Until the first wrap after a refill, every read hits an entry that was
    // never written since, so the fill value stands in for the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_pass <= 1'b1;
            r_rd_fresh   <= 1'b0;
            r_byp_valid  <= 1'b0;
            r_fill.sgn   <= SGN_POS;
            r_fill.mag   <= RST_INIT_STEP;
        end else begin
            if (i_refill) begin
                r_first_pass <= 1'b1;
                r_fill.sgn   <= (i_init_step == '0) ? SGN_ZERO : SGN_POS;
                r_fill.mag   <= i_init_step;
            end else if (i_rd_en && i_rd_last) begin
                r_first_pass <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_fresh <= r_first_pass;
            end
            if (i_refill) begin
                r_byp_valid <= 1'b0;
            end else if (i_wr_en) begin
                r_byp_valid <= 1'b1;
            end
        end
    end

    // A read taken at the same edge as a write to its entry sees the old data.
    assign byp_hit   = r_byp_valid && (r_byp_idx == r_rd_idx);
    assign o_rd_data = byp_hit ? r_byp_data : (r_rd_fresh ? r_fill : r_rd_data);
    assign o_rd_idx  = r_rd_idx;

    a_refill_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_refill |=> r_first_pass && !r_byp_valid)
        else $error("refill did not restart the fill pass");

    a_wrap_ends_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en && i_rd_last && !i_refill |=> !r_first_pass)
        else $error("fill pass survived a wrap");

endmodule

`default_nettype wire

FILE: rtl/rprop_calc.sv
// Step update of one element: sign compare, Q2.16 scaling with round half up,
// clamping, and the signed update. Depends on rprop_pkg.
`default_nettype none

module rprop_calc
    import rprop_pkg::*;
(
    input  wire t_entry             i_prev,
    input  wire t_sgn               i_grad_sgn,
    input  wire t_cfg               i_cfg,
    output t_entry                  o_entry,
    output logic signed [UPD_W-1:0] o_update
);

    logic                scale_en;
    logic [ETA_W-1:0]    eta;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] cand;
    logic [STEP_W-1:0]   step;
    logic [UPD_W-1:0]    mag_ext;

    assign scale_en = (i_grad_sgn != SGN_ZERO) && (i_prev.sgn != SGN_ZERO);
    assign eta      = (i_grad_sgn == i_prev.sgn) ? i_cfg.grow_rate : i_cfg.shrink_rate;
    assign prod     = PROD_W'(i_prev.mag) * PROD_W'(eta) + ROUND_HALF;
    assign scaled   = prod[PROD_W-1:ETA_FRAC];
    assign cand     = scale_en ? scaled : SCALED_W'(i_prev.mag);

    // With crossed limits, the lower one wins below it and the upper one elsewhere.
    always_comb begin
        if (cand < SCALED_W'(i_cfg.min_step)) begin
            step = i_cfg.min_step;
        end else if (cand > SCALED_W'(i_cfg.max_step)) begin
            step = i_cfg.max_step;
        end else begin
            step = cand[STEP_W-1:0];
        end
    end

    assign mag_ext = UPD_W'(step);

    always_comb begin
        if (i_grad_sgn == SGN_ZERO || step == '0) begin
            o_entry.sgn = SGN_ZERO;
            o_entry.mag = '0;
        end else begin
            o_entry.sgn = i_grad_sgn;
            o_entry.mag = step;
        end
        unique case (i_grad_sgn)
            SGN_POS: o_update = mag_ext;
            SGN_NEG: o_update = -mag_ext;
            default: o_update = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/rprop_step_update.sv
// RPROP step-size updater, top level: input and output handshakes, position
// counter, execute stage and output register. Depends on rprop_pkg, rprop_cfg,
// rprop_store and rprop_calc.
//
// Usage: gradient elements arrive one per transfer on the input channel
// (i_in_valid, o_in_ready, i_gradient), in weight order. Each one yields exactly
// one result on the output channel (o_out_valid, i_out_ready, o_update,
// o_last_of_vector); o_last_of_vector marks the final position of the vector.
// Order: an element accepted at a clock edge has its store entry read at that
// edge, its update computed in the execute stage and registered in the output
// register once the execute stage advances, so results leave in order.
// Throughput: one element per cycle, sustained while the receiver takes results,
// for any vector length. The bound on the clock is the loop from the last-write
// bypass through the 40x18 multiplier, the rounding add and the clamp compares.
// When the receiver stalls, the output register holds its result and the
// execute stage holds one more; input is refused only when both are full.
// Reset restores the register defaults, sets the position to zero and makes
// every entry read as the default initial step; a vector_length write does the
// same with the present init_step. Neither needs a clearing pass.
`default_nettype none

module rprop_step_update
    import rprop_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [GRAD_W-1:0] i_gradient,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [UPD_W-1:0]      o_update,
    output logic                         o_last_of_vector
);

    t_cfg                    cfg;
    logic                    refill;
    logic                    accept;
    logic                    x_adv;
    logic                    wr_en;
    logic                    pos_last;
    t_sgn                    grad_sgn;
    t_entry                  prev;
    t_entry                  new_entry;
    logic [IDX_W-1:0]        x_idx;
    logic signed [UPD_W-1:0] update;

    logic                    r_x_valid;
    t_sgn                    r_x_sgn;
    logic                    r_x_last;
    logic [IDX_W-1:0]        r_pos;
    logic                    r_o_valid;
    logic signed [UPD_W-1:0] r_o_update;
    logic                    r_o_last;

    rprop_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_refill   (refill)
    );

    assign x_adv      = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_x_valid || x_adv;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_en      = r_x_valid && x_adv;
    assign pos_last   = (r_pos == cfg.last_pos);

    always_comb begin
        if (i_gradient == '0) begin
            grad_sgn = SGN_ZERO;
        end else if (i_gradient[GRAD_W-1]) begin
            grad_sgn = SGN_NEG;
        end else begin
            grad_sgn = SGN_POS;
        end
    end

    rprop_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_refill    (refill),
        .i_init_step (cfg.init_step),
        .i_rd_en     (accept),
        .i_rd_idx    (r_pos),
        .i_rd_last   (pos_last),
        .i_wr_en     (wr_en),
        .i_wr_data   (new_entry),
        .o_rd_data   (prev),
        .o_rd_idx    (x_idx)
    );

    rprop_calc u_calc (
        .i_prev     (prev),
        .i_grad_sgn (r_x_sgn),
        .i_cfg      (cfg),
        .o_entry    (new_entry),
        .o_update   (update)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_x_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (refill) begin
                r_pos <= '0;
            end else if (accept) begin
                r_pos <= pos_last ? '0 : r_pos + IDX_W'(1);
            end
            if (accept) begin
                r_x_valid <= 1'b1;
            end else if (x_adv) begin
                r_x_valid <= 1'b0;
            end
            if (wr_en) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_sgn  <= grad_sgn;
            r_x_last <= pos_last;
        end
        if (wr_en) begin
            r_o_update <= update;
            r_o_last   <= r_x_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_update         = r_o_update;
    assign o_last_of_vector = r_o_last;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= cfg.last_pos)
        else $error("position counter ran past the vector length");

    a_exec_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_valid && !x_adv |=> r_x_valid)
        else $error("stalled element dropped from the execute stage");

    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_o_valid && (x_idx == $past(x_idx) || $past(accept)))
        else $error("written element did not reach the output register");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_x_valid)
        else $error("accepted element missing from the execute stage");

endmodule

`default_nettype wire
